// ===== rtl/aenv_pkg.sv =====
package aenv_pkg;

  // Field widths
  localparam int TIME_W    = 32;
  localparam int DUR_W     = 24;
  localparam int LEVEL_W   = 17;
  localparam int NUM_W     = DUR_W + LEVEL_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = DUR_W;
  localparam int S_DATA_W  = 3 * TIME_W;
  localparam int M_DATA_W  = 24;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START   = 3'd4;

  // Register reset values
  localparam logic [DUR_W-1:0]   RST_ATTACK  = 24'd4800;
  localparam logic [DUR_W-1:0]   RST_DECAY   = 24'd4800;
  localparam logic [LEVEL_W-1:0] RST_SUSTAIN = 17'd65536;
  localparam logic [DUR_W-1:0]   RST_RELEASE = 24'd9600;
  localparam logic [LEVEL_W-1:0] RST_START   = 17'd65536;

  // Envelope phase codes
  localparam logic [1:0] PH_ATTACK  = 2'd0;
  localparam logic [1:0] PH_DECAY   = 2'd1;
  localparam logic [1:0] PH_SUSTAIN = 2'd2;
  localparam logic [1:0] PH_RELEASE = 2'd3;

  // How the held level is formed from the first quotient
  localparam logic [1:0] HS_QUOT  = 2'd0;
  localparam logic [1:0] HS_UP    = 2'd1;
  localparam logic [1:0] HS_DOWN  = 2'd2;
  localparam logic [1:0] HS_CONST = 2'd3;

  // How the final level is formed from the held level and second quotient
  localparam logic [1:0] RK_NONE = 2'd0;
  localparam logic [1:0] RK_HOLD = 2'd1;
  localparam logic [1:0] RK_ZERO = 2'd2;
  localparam logic [1:0] RK_RAMP = 2'd3;

  typedef struct packed {
    logic [DUR_W-1:0]   attack_ticks;
    logic [DUR_W-1:0]   decay_ticks;
    logic [LEVEL_W-1:0] sustain_level;
    logic [DUR_W-1:0]   release_ticks;
    logic [LEVEL_W-1:0] start_level;
  } aenv_cfg_t;

  // Per-item information that rides along with the division chains
  typedef struct packed {
    logic [1:0]         phase;
    logic [1:0]         hsel;
    logic [LEVEL_W-1:0] const_level;
    logic [1:0]         rel_kind;
    logic [DUR_W-1:0]   t_rel;
    logic [LEVEL_W-1:0] base;
  } aenv_side_t;

  // Division word: partial remainder, numerator bits shifting out while
  // quotient bits shift in, the divisor and the sideband.
  typedef struct packed {
    logic [DUR_W-1:0]   rem;
    logic [LEVEL_W-1:0] nq;
    logic [DUR_W-1:0]   divisor;
    aenv_side_t         side;
  } aenv_div_t;

endpackage

// ===== rtl/aenv_div_cell.sv =====
module aenv_div_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  aenv_pkg::aenv_div_t din,
  output logic                out_valid,
  output aenv_pkg::aenv_div_t dout
);
  import aenv_pkg::*;

  logic [DUR_W:0]   trial;
  logic [DUR_W:0]   diff;
  logic             ge;
  aenv_div_t        dout_next;

  // One restoring division step: bring down the next numerator bit,
  // subtract the divisor when it fits and shift in the quotient bit.
  always_comb begin
    trial = {din.rem, din.nq[LEVEL_W-1]};
    diff  = trial - {1'b0, din.divisor};
    ge    = (trial >= {1'b0, din.divisor});
    dout_next         = din;
    dout_next.rem     = ge ? diff[DUR_W-1:0] : trial[DUR_W-1:0];
    dout_next.nq      = {din.nq[LEVEL_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end
  end

endmodule

// ===== rtl/aenv_divider.sv =====
module aenv_divider (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  aenv_pkg::aenv_div_t din,
  output logic                out_valid,
  output aenv_pkg::aenv_div_t dout
);
  import aenv_pkg::*;

  aenv_div_t link  [0:LEVEL_W];
  logic      vlink [0:LEVEL_W];

  assign link[0]  = din;
  assign vlink[0] = in_valid;

  // A row of division cells, one quotient bit per cell, most significant first.
  for (genvar i = 0; i < LEVEL_W; i++) begin : g_cell
    aenv_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (vlink[i]),
      .din      (link[i]),
      .out_valid(vlink[i+1]),
      .dout     (link[i+1])
    );
  end

  assign dout      = link[LEVEL_W];
  assign out_valid = vlink[LEVEL_W];

endmodule

// ===== rtl/aenv_front.sv =====
module aenv_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  aenv_pkg::aenv_cfg_t         cfg,
  input  logic                        in_valid,
  input  logic [aenv_pkg::TIME_W-1:0] now_time,
  input  logic [aenv_pkg::TIME_W-1:0] on_time,
  input  logic [aenv_pkg::TIME_W-1:0] off_time,
  output logic                        out_valid,
  output aenv_pkg::aenv_div_t         dout
);
  import aenv_pkg::*;

  // Stage 0: elapsed times
  logic              s0_valid;
  logic              s0_note_on;
  logic              s0_early_zero;
  logic [TIME_W-1:0] s0_life;
  logic [TIME_W-1:0] s0_t;

  logic              note_on;

  // Stage 1: segment decode and multiplier operands
  logic               s1_valid;
  aenv_side_t         s1_side;
  logic [DUR_W-1:0]   s1_mop;
  logic [LEVEL_W-1:0] s1_factor;
  logic [DUR_W-1:0]   s1_divisor;

  logic [DUR_W:0]     att_dec;
  logic               in_att;
  logic               in_dec;
  logic               dec_up;
  logic [LEVEL_W-1:0] lvl_diff;
  logic [DUR_W-1:0]   dec_life;
  aenv_side_t         side_next;
  logic [DUR_W-1:0]   mop_next;
  logic [LEVEL_W-1:0] factor_next;
  logic [DUR_W-1:0]   divisor_next;

  logic [NUM_W-1:0]   product;

  assign note_on = (on_time > off_time);

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s0_valid  <= in_valid;
      s1_valid  <= s0_valid;
      out_valid <= s1_valid;
    end
  end

  // Held time is measured to now while the note is on, to the release otherwise.
  always_ff @(posedge clk) begin
    if (en) begin
      s0_note_on    <= note_on;
      s0_early_zero <= note_on && (now_time < on_time);
      s0_life       <= note_on ? (now_time - on_time) : (off_time - on_time);
      s0_t          <= (now_time > off_time) ? (now_time - off_time) : '0;
    end
  end

  // Decide the segment and set up the ramp product and divisor.
  always_comb begin
    att_dec  = {1'b0, cfg.attack_ticks} + {1'b0, cfg.decay_ticks};
    in_att   = (s0_life <= {{(TIME_W-DUR_W){1'b0}}, cfg.attack_ticks});
    in_dec   = (s0_life <= {{(TIME_W-DUR_W-1){1'b0}}, att_dec});
    dec_up   = (cfg.sustain_level >= cfg.start_level);
    lvl_diff = dec_up ? (cfg.sustain_level - cfg.start_level)
                      : (cfg.start_level - cfg.sustain_level);
    dec_life = s0_life[DUR_W-1:0] - cfg.attack_ticks;

    side_next             = '0;
    side_next.phase       = PH_SUSTAIN;
    side_next.hsel        = HS_CONST;
    side_next.const_level = cfg.sustain_level;
    mop_next              = dec_life;
    factor_next           = lvl_diff;
    divisor_next          = cfg.decay_ticks;

    if (s0_early_zero) begin
      side_next.phase       = PH_ATTACK;
      side_next.const_level = '0;
    end else if (in_att) begin
      side_next.phase = PH_ATTACK;
      mop_next        = s0_life[DUR_W-1:0];
      factor_next     = cfg.start_level;
      divisor_next    = cfg.attack_ticks;
      if (cfg.attack_ticks == '0) begin
        side_next.const_level = '0;
      end else begin
        side_next.hsel = HS_QUOT;
      end
    end else if (in_dec) begin
      side_next.phase = PH_DECAY;
      if (cfg.decay_ticks == '0) begin
        side_next.const_level = cfg.start_level;
      end else begin
        side_next.hsel = dec_up ? HS_UP : HS_DOWN;
      end
    end

    // Release handling is decided here as well; the level follows later.
    side_next.t_rel = s0_t[DUR_W-1:0];
    if (s0_note_on) begin
      side_next.rel_kind = RK_NONE;
    end else begin
      side_next.phase = PH_RELEASE;
      if (s0_t == '0) begin
        side_next.rel_kind = RK_HOLD;
      end else if (s0_t >= {{(TIME_W-DUR_W){1'b0}}, cfg.release_ticks}) begin
        side_next.rel_kind = RK_ZERO;
      end else begin
        side_next.rel_kind = RK_RAMP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side    <= side_next;
      s1_mop     <= mop_next;
      s1_factor  <= factor_next;
      s1_divisor <= divisor_next;
    end
  end

  // Stage 2: ramp product loaded into the division word.
  assign product = NUM_W'(s1_mop) * NUM_W'(s1_factor);

  always_ff @(posedge clk) begin
    if (en) begin
      dout.rem     <= product[NUM_W-1:LEVEL_W];
      dout.nq      <= product[LEVEL_W-1:0];
      dout.divisor <= s1_divisor;
      dout.side    <= s1_side;
    end
  end

endmodule

// ===== rtl/adsr_envelope_level.sv =====
// ADSR envelope level, one voice sample per beat.
// Input channel s_*: one beat carries now_time, on_time and off_time in
// sample ticks. Output channel m_*: one beat carries the Q16 level, the
// phase (attack, decay, sustain, release) and a finished flag.
// Every input beat gives exactly one output beat, in order.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 attack, 1 decay, 2 sustain, 3 release, 4 start level); change it only
// while no beat is in flight. Other indexes are ignored.
// Throughput: one beat per cycle while the skid register is empty. The
// datapath is a pipeline of 40 registers: front-end decode and multiply,
// a row of 17 division cells for the attack or decay ramp, a second
// multiply and a second row of 17 cells for the release ramp, then the
// output register.
// When the receiver stalls, the output register holds and one more result
// lands in a skid register; s_tready then drops and the whole pipeline
// freezes until the skid register empties. s_tready does not depend on
// m_tready combinationally.
// Reset clears all valid state and loads the default register values.
module adsr_envelope_level (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration write port
  input  logic                          cfg_we,
  input  logic [aenv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [aenv_pkg::CFG_W-1:0]    cfg_data,
  // Input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // s_tdata: now_time [31:0], on_time [63:32], off_time [95:64]
  input  logic [aenv_pkg::S_DATA_W-1:0] s_tdata,
  // Output stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // m_tdata: level [16:0], phase [18:17], finished [19], zero pad [23:20]
  output logic [aenv_pkg::M_DATA_W-1:0] m_tdata
);
  import aenv_pkg::*;

  localparam int OUT_W = LEVEL_W + 3;

  aenv_cfg_t          cfg;

  logic               adv;
  logic               front_valid;
  aenv_div_t          front_out;
  logic               div1_valid;
  aenv_div_t          div1_out;

  logic               s3_valid;
  aenv_side_t         s3_side;
  aenv_side_t         side_held;
  logic [LEVEL_W-1:0] held;

  logic               s4_valid;
  aenv_div_t          s4_div;
  logic [NUM_W-1:0]   rel_product;

  logic               div2_valid;
  aenv_div_t          div2_out;

  logic [LEVEL_W-1:0] level;
  logic [OUT_W-1:0]   result;

  logic               skid_valid;
  logic [OUT_W-1:0]   skid_data;
  logic [OUT_W-1:0]   out_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attack_ticks  <= RST_ATTACK;
      cfg.decay_ticks   <= RST_DECAY;
      cfg.sustain_level <= RST_SUSTAIN;
      cfg.release_ticks <= RST_RELEASE;
      cfg.start_level   <= RST_START;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ATTACK:  cfg.attack_ticks  <= cfg_data;
        REG_DECAY:   cfg.decay_ticks   <= cfg_data;
        REG_SUSTAIN: cfg.sustain_level <= cfg_data[LEVEL_W-1:0];
        REG_RELEASE: cfg.release_ticks <= cfg_data;
        REG_START:   cfg.start_level   <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the skid register is free.
  assign adv      = !skid_valid;
  assign s_tready = adv;

  aenv_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .now_time (s_tdata[TIME_W-1:0]),
    .on_time  (s_tdata[2*TIME_W-1:TIME_W]),
    .off_time (s_tdata[3*TIME_W-1:2*TIME_W]),
    .out_valid(front_valid),
    .dout     (front_out)
  );

  aenv_divider u_div_hold (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (front_valid),
    .din      (front_out),
    .out_valid(div1_valid),
    .dout     (div1_out)
  );

  // Held level from the attack or decay quotient.
  always_comb begin
    case (div1_out.side.hsel)
      HS_QUOT: held = div1_out.nq;
      HS_UP:   held = cfg.start_level + div1_out.nq;
      HS_DOWN: held = cfg.start_level - div1_out.nq;
      default: held = div1_out.side.const_level;
    endcase
    side_held      = div1_out.side;
    side_held.base = held;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= div1_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_side <= side_held;
    end
  end

  // Release drop product: elapsed release time times the held level.
  assign rel_product = NUM_W'(s3_side.t_rel) * NUM_W'(s3_side.base);

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_div.rem     <= rel_product[NUM_W-1:LEVEL_W];
      s4_div.nq      <= rel_product[LEVEL_W-1:0];
      s4_div.divisor <= cfg.release_ticks;
      s4_div.side    <= s3_side;
    end
  end

  aenv_divider u_div_rel (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (s4_valid),
    .din      (s4_div),
    .out_valid(div2_valid),
    .dout     (div2_out)
  );

  // Final level after release.
  always_comb begin
    case (div2_out.side.rel_kind)
      RK_ZERO: level = '0;
      RK_RAMP: level = div2_out.side.base - div2_out.nq;
      default: level = div2_out.side.base;
    endcase
    result = {(level == '0), div2_out.side.phase, level};
  end

  // Output register with skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_tready) begin
        skid_valid <= 1'b0;
      end
    end else if (div2_valid) begin
      if (!m_tvalid || m_tready) begin
        m_tvalid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (m_tready) begin
        out_data <= skid_data;
      end
    end else if (div2_valid) begin
      if (!m_tvalid || m_tready) begin
        out_data <= result;
      end else begin
        skid_data <= result;
      end
    end
  end

  assign m_tdata = {{(M_DATA_W-OUT_W){1'b0}}, out_data};

  // The skid register only fills behind a full output register.
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> m_tvalid)
    else $error("skid register holds a result while the output is empty");

  // Input backpressure only appears after a stalled output beat.
  assert property (@(posedge clk) disable iff (rst)
    $fell(s_tready) |-> $past(m_tvalid && !m_tready))
    else $error("s_tready dropped without a stalled output beat");

  // The finished flag marks a zero level.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[LEVEL_W+2] == (m_tdata[LEVEL_W-1:0] == '0)))
    else $error("finished flag disagrees with the level");

endmodule

// ===== tb/sv/adsr_envelope_checker.sv =====
// Watches the configuration port and both stream channels, predicts the
// envelope sample for every accepted input beat and compares each output
// beat with the oldest prediction still waiting.
module adsr_envelope_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [aenv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [aenv_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  // s_tdata: now_time [31:0], on_time [63:32], off_time [95:64]
  input  logic [aenv_pkg::S_DATA_W-1:0]  s_tdata,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  // m_tdata: level [16:0], phase [18:17], finished [19], zero pad [23:20]
  input  logic [aenv_pkg::M_DATA_W-1:0]  m_tdata,
  output int                             errors,
  output int                             pending
);
  import aenv_pkg::*;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [1:0]         phase;
    logic               finished;
  } env_sample_t;

  aenv_cfg_t   env_regs;
  env_sample_t samples_due[$];

  // Level of a held note after a non-negative number of ticks; also gives
  // the phase it is in.
  function automatic logic [63:0] held_level(input logic [63:0] life,
                                             output logic [1:0] ph);
    logic [63:0] att, dcy, sus, peak, d;
    att  = env_regs.attack_ticks;
    dcy  = env_regs.decay_ticks;
    sus  = env_regs.sustain_level;
    peak = env_regs.start_level;
    if (life <= att) begin
      ph = PH_ATTACK;
      if (att == 0) return 64'd0;
      return (life * peak) / att;
    end
    if (life <= att + dcy) begin
      ph = PH_DECAY;
      d  = life - att;
      if (dcy == 0) return peak;
      if (sus >= peak) return peak + (d * (sus - peak)) / dcy;
      return peak - (d * (peak - sus)) / dcy;
    end
    ph = PH_SUSTAIN;
    return sus;
  endfunction

  // Full envelope sample for one set of note times.
  function automatic env_sample_t envelope_sample(input logic [TIME_W-1:0] now,
                                                  input logic [TIME_W-1:0] on,
                                                  input logic [TIME_W-1:0] off);
    env_sample_t r;
    logic [63:0] lvl, rel, t, drop, rel_len;
    logic [1:0]  ph, rel_ph;
    rel_len = env_regs.release_ticks;
    if (on > off) begin
      if (now < on) begin
        lvl = 64'd0;
        ph  = PH_ATTACK;
      end else begin
        lvl = held_level(64'(now - on), ph);
      end
    end else begin
      // The release starts from whatever level the note had reached.
      rel = held_level(64'(off - on), rel_ph);
      t   = (now > off) ? 64'(now - off) : 64'd0;
      ph  = PH_RELEASE;
      if (t == 0) begin
        lvl = rel;
      end else if (t >= rel_len) begin
        lvl = 64'd0;
      end else begin
        drop = (t * rel) / rel_len;
        lvl  = (drop >= rel) ? 64'd0 : rel - drop;
      end
    end
    r.level    = lvl[LEVEL_W-1:0];
    r.phase    = ph;
    r.finished = (r.level == '0);
    return r;
  endfunction

  // Track register writes, queue predictions and compare output beats.
  always @(posedge clk) begin
    env_sample_t got, want;
    if (rst) begin
      env_regs.attack_ticks  = RST_ATTACK;
      env_regs.decay_ticks   = RST_DECAY;
      env_regs.sustain_level = RST_SUSTAIN;
      env_regs.release_ticks = RST_RELEASE;
      env_regs.start_level   = RST_START;
      samples_due.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ATTACK:  env_regs.attack_ticks  = cfg_data[DUR_W-1:0];
          REG_DECAY:   env_regs.decay_ticks   = cfg_data[DUR_W-1:0];
          REG_SUSTAIN: env_regs.sustain_level = cfg_data[LEVEL_W-1:0];
          REG_RELEASE: env_regs.release_ticks = cfg_data[DUR_W-1:0];
          REG_START:   env_regs.start_level   = cfg_data[LEVEL_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        samples_due.push_back(envelope_sample(s_tdata[TIME_W-1:0],
                                              s_tdata[2*TIME_W-1:TIME_W],
                                              s_tdata[3*TIME_W-1:2*TIME_W]));
      if (m_tvalid && m_tready) begin
        got.level    = m_tdata[LEVEL_W-1:0];
        got.phase    = m_tdata[LEVEL_W+1:LEVEL_W];
        got.finished = m_tdata[LEVEL_W+2];
        if (samples_due.size() == 0) begin
          $error("output beat with nothing outstanding: level %0d phase %0d",
                 got.level, got.phase);
          errors++;
        end else begin
          want = samples_due.pop_front();
          if (got.level !== want.level) begin
            $error("level: expected %0d, got %0d", want.level, got.level);
            errors++;
          end
          if (got.phase !== want.phase) begin
            $error("phase: expected %0d, got %0d", want.phase, got.phase);
            errors++;
          end
          if (got.finished !== want.finished) begin
            $error("finished: expected %0d, got %0d", want.finished, got.finished);
            errors++;
          end
        end
      end
    end
    pending = samples_due.size();
  end

endmodule

// ===== tb/sv/tb_adsr_envelope_level.sv =====
// Drives note timing samples into the envelope block under a series of
// register settings and leaves all checking to the checker beside it.
module tb_adsr_envelope_level;
  import aenv_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int NOTES_PER_SET = 87;
  localparam int RANDOM_SETS   = 10;
  localparam int DUR_MAX       = (1 << DUR_W) - 1;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
  localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(1 << (LEVEL_W - 1));
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = REG_START + 1'b1;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_DATA_W-1:0]  s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_DATA_W-1:0]  m_tdata;
  int                   errors;
  int                   pending;

  // Stimulus shaping only: which durations are programmed right now.
  int unsigned attack_len;
  int unsigned decay_len;
  int unsigned release_len;
  bit          calm;
  logic        hold_req;

  adsr_envelope_level u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  adsr_envelope_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    m_tready  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_tready <= calm || ($urandom_range(0, 99) >= 28);
      end
    end
  end

  // Watchdog: ends the run when no beat moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("adsr_envelope_level test failed");
    $finish;
  end

  task automatic send_sample(input logic [TIME_W-1:0] now,
                             input logic [TIME_W-1:0] on,
                             input logic [TIME_W-1:0] off);
    while (!calm && $urandom_range(0, 99) < 28) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {off, on, now};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stops offering beats and waits until every sample has come back.
  task automatic drain_voices();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Writes all five registers; level registers may carry junk above bit 16.
  task automatic program_envelope(input int unsigned att, input int unsigned dcy,
                                  input logic [LEVEL_W-1:0] sus, input int unsigned rel,
                                  input logic [LEVEL_W-1:0] peak, input bit junk);
    logic [CFG_W-LEVEL_W-1:0] upper;
    upper       = junk ? (CFG_W-LEVEL_W)'($urandom) : '0;
    attack_len  = att;
    decay_len   = dcy;
    release_len = rel;
    set_reg(REG_ATTACK, att[CFG_W-1:0]);
    set_reg(REG_DECAY, dcy[CFG_W-1:0]);
    set_reg(REG_SUSTAIN, {upper, sus});
    set_reg(REG_RELEASE, rel[CFG_W-1:0]);
    set_reg(REG_START, {upper, peak});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Elapsed time aimed mostly at the attack, decay and sustain boundaries.
  function automatic logic [TIME_W-1:0] pick_life();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, attack_len);
      1:       return attack_len + $urandom_range(0, 2) - 1;
      2:       return attack_len + $urandom_range(0, decay_len);
      3:       return attack_len + decay_len + $urandom_range(0, 2) - 1;
      4:       return attack_len + decay_len + $urandom_range(1, 1000);
      5:       return $urandom;
      default: return $urandom_range(0, attack_len + decay_len + 2);
    endcase
  endfunction

  function automatic int unsigned pick_duration();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return DUR_MAX;
      2, 3:    return $urandom_range(1, 20000);
      default: return $urandom_range(1, 64);
    endcase
  endfunction

  function automatic logic [LEVEL_W-1:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return LEVEL_ONE;
      2:       return LEVEL_MAX;
      3:       return LEVEL_W'($urandom);
      default: return LEVEL_W'($urandom_range(0, LEVEL_ONE));
    endcase
  endfunction

  // One sample of a held note, a released note, or plain noise.
  task automatic play_note();
    logic [TIME_W-1:0] now, on, off, t;
    on = $urandom;
    if ($urandom_range(0, 99) < 25) begin
      send_sample($urandom, $urandom, $urandom);
    end else if ($urandom_range(0, 1) == 1) begin
      off = on - 1 - $urandom_range(0, 4095);
      now = ($urandom_range(0, 9) == 0) ? on - $urandom_range(1, 100) : on + pick_life();
      send_sample(now, on, off);
    end else begin
      off = on + pick_life();
      case ($urandom_range(0, 5))
        0:       t = 0;
        1:       t = release_len - 1;
        2:       t = release_len;
        3:       t = release_len + 1;
        4:       t = $urandom_range(1, release_len);
        default: t = $urandom;
      endcase
      now = ($urandom_range(0, 9) == 0) ? off - $urandom_range(1, 100) : off + t;
      send_sample(now, on, off);
    end
  endtask

  task automatic play_notes(input int count);
    for (int i = 0; i < count; i++) play_note();
  endtask

  initial begin
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    attack_len  = RST_ATTACK;
    decay_len   = RST_DECAY;
    release_len = RST_RELEASE;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: time extremes and each envelope segment.
    send_sample(32'd0, 32'd0, 32'd0);
    send_sample('1, '1, '1);
    send_sample(32'd100, 32'd200, 32'd50);
    send_sample(32'd0, '1, 32'hFFFF_FFFE);
    send_sample('1, '1, 32'd0);
    send_sample(32'd3400, 32'd1000, 32'd0);
    send_sample(32'd5800, 32'd1000, 32'd0);
    send_sample(32'd5801, 32'd1000, 32'd0);
    send_sample(32'd10600, 32'd1000, 32'd0);
    send_sample(32'd10601, 32'd1000, 32'd0);
    send_sample('1, 32'd1, 32'd0);
    send_sample(32'd2400, 32'd0, 32'd2400);
    send_sample(32'd2395, 32'd0, 32'd2400);
    send_sample(32'd7200, 32'd0, 32'd2400);
    send_sample(32'd11999, 32'd0, 32'd2400);
    send_sample(32'd12000, 32'd0, 32'd2400);
    send_sample('1, 32'd0, 32'd2400);
    send_sample(32'd9000, 32'd0, 32'd6000);
    play_notes(60);
    drain_voices();

    // Shortest ramps, zero sustain.
    program_envelope(1, 1, '0, 1, LEVEL_ONE, 1'b0);
    play_notes(NOTES_PER_SET);
    drain_voices();

    // Zero-length ramps and full-scale levels.
    program_envelope(0, 0, LEVEL_MAX, 0, LEVEL_MAX, 1'b0);
    play_notes(NOTES_PER_SET);
    drain_voices();

    // Longest ramps with the decay rising from a zero peak.
    program_envelope(DUR_MAX, DUR_MAX, LEVEL_ONE, DUR_MAX, '0, 1'b1);
    play_notes(NOTES_PER_SET);
    drain_voices();

    for (int k = 0; k < RANDOM_SETS; k++) begin
      program_envelope(pick_duration(), pick_duration(), pick_level(),
                       pick_duration(), pick_level(), 1'($urandom_range(0, 1)));
      // Writes to unused indexes must leave the envelope alone.
      for (int r = REG_SPARE; r < (1 << CFG_IDX_W); r++)
        set_reg(CFG_IDX_W'(r), CFG_W'($urandom));
      cfg_we <= 1'b0;
      @(posedge clk);
      calm = (k == 0);
      if (k == 1) hold_req <= 1'b1;
      play_notes(NOTES_PER_SET);
      drain_voices();
    end
    calm = 1'b0;

    repeat (60) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("adsr_envelope_level test passed");
    else
      $display("adsr_envelope_level test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/aenv_pkg.sv
rtl/aenv_div_cell.sv
rtl/aenv_divider.sv
rtl/aenv_front.sv
rtl/adsr_envelope_level.sv
tb/sv/adsr_envelope_checker.sv
tb/sv/tb_adsr_envelope_level.sv
